FILE: src/eul2q_pkg.sv
// ----------------------------------------------------------------------------
// eul2q_pkg
// Types and constants shared by the Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package eul2q_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int CW = 34;

  typedef logic signed [CW-1:0] cword_t;
  typedef logic signed [31:0]   trig_t;

  localparam cword_t GAIN_Q30    = 34'sd652032874;
  localparam cword_t HALF_PI_Q30 = 34'sd1686629713;
  localparam cword_t PI_Q30      = 34'sd3373259426;

  localparam logic [0:0] REG_COMPONENT_ORDER = 1'b0;

  localparam cword_t ATAN_Q30 [ATAN_ENTRIES] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] component_a;
    logic signed [15:0] component_b;
    logic signed [15:0] component_c;
    logic signed [15:0] component_d;
  } result_t;

endpackage

FILE: src/eul2q_cordic_lane.sv
// ----------------------------------------------------------------------------
// eul2q_cordic_lane
// Pipelined rotation-mode CORDIC: sine and cosine of half an angle, Q2.30.
// ----------------------------------------------------------------------------
module eul2q_cordic_lane import eul2q_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic signed [15:0] angle,
  output trig_t              sin_out,
  output trig_t              cos_out
);

  cword_t x [0:STAGES];
  cword_t y [0:STAGES];
  cword_t z [0:STAGES];
  logic   flip [0:STAGES];

  cword_t z_in;
  assign z_in = CW'(angle) <<< 16;

  // quadrant fold
  always_ff @(posedge clk) begin
    x[0] <= GAIN_Q30;
    y[0] <= '0;
    if (z_in > HALF_PI_Q30) begin
      z[0]    <= z_in - PI_Q30;
      flip[0] <= 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      z[0]    <= z_in + PI_Q30;
      flip[0] <= 1'b1;
    end else begin
      z[0]    <= z_in;
      flip[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATAN_Q30[i];
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATAN_Q30[i];
      end
    end
  end

  assign cos_out = flip[STAGES] ? trig_t'(-x[STAGES]) : trig_t'(x[STAGES]);
  assign sin_out = flip[STAGES] ? trig_t'(-y[STAGES]) : trig_t'(y[STAGES]);

endmodule

FILE: src/eul2q_merge.sv
// ----------------------------------------------------------------------------
// eul2q_merge
// Combines the three lanes' sines and cosines into the quaternion, Q1.14.
// ----------------------------------------------------------------------------
module eul2q_merge import eul2q_pkg::*; (
  input  logic    clk,
  input  trig_t   sx,
  input  trig_t   cx,
  input  trig_t   sy,
  input  trig_t   cy,
  input  trig_t   sz,
  input  trig_t   cz,
  input  logic    order,
  output result_t result
);

  typedef logic signed [63:0] prod_t;

  function automatic trig_t rnd30(prod_t p);
    prod_t t;
    t = (p + 64'sd536870912) >>> 30;
    return t[31:0];
  endfunction

  function automatic logic signed [15:0] to_q14(logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd32768) >>> 16;
    if (r > 33'sd16384) r = 33'sd16384;
    if (r < -33'sd16384) r = -33'sd16384;
    return r[15:0];
  endfunction

  prod_t p_cc, p_ss, p_sc, p_cs;
  trig_t sz_a, cz_a;
  prod_t t_ccc, t_sss, t_scc, t_css, t_csc, t_scs, t_ccs, t_ssc;

  always_ff @(posedge clk) begin
    p_cc <= cx * cy;
    p_ss <= sx * sy;
    p_sc <= sx * cy;
    p_cs <= cx * sy;
    sz_a <= sz;
    cz_a <= cz;
  end

  always_ff @(posedge clk) begin
    t_ccc <= rnd30(p_cc) * cz_a;
    t_sss <= rnd30(p_ss) * sz_a;
    t_scc <= rnd30(p_sc) * cz_a;
    t_css <= rnd30(p_cs) * sz_a;
    t_csc <= rnd30(p_cs) * cz_a;
    t_scs <= rnd30(p_sc) * sz_a;
    t_ccs <= rnd30(p_cc) * sz_a;
    t_ssc <= rnd30(p_ss) * cz_a;
  end

  logic signed [15:0] qw, qx, qy, qz;
  assign qw = to_q14(33'(rnd30(t_ccc)) + 33'(rnd30(t_sss)));
  assign qx = to_q14(33'(rnd30(t_scc)) - 33'(rnd30(t_css)));
  assign qy = to_q14(33'(rnd30(t_csc)) + 33'(rnd30(t_scs)));
  assign qz = to_q14(33'(rnd30(t_ccs)) - 33'(rnd30(t_ssc)));

  always_ff @(posedge clk) begin
    if (order == 1'b0) begin
      result <= '{component_a: qw, component_b: qx, component_c: qy, component_d: qz};
    end else begin
      result <= '{component_a: qx, component_b: qy, component_c: qz, component_d: qw};
    end
  end

endmodule

FILE: src/euler_to_quaternion_converter_top.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_converter_top
// Converts roll/pitch/yaw (Q2.13 rad) into a unit quaternion (Q1.14).
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low; busy is always
//   low, so a new angle set may be given every cycle.
//   Three CORDIC lanes, one per angle, run in parallel; a merge pipeline
//   forms the triple products, rounds, clamps and orders the components.
//   From start to done the pipeline has one fold stage, one stage per
//   CORDIC iteration and three merge stages. Throughput is one
//   transaction per cycle.
//   done marks the result for exactly one cycle; the receiver cannot stall,
//   so every result must be taken when shown.
//   component_order (APB, address 0): 0 gives W,X,Y,Z; 1 gives X,Y,Z,W.
//   Synchronous reset clears the pipeline valid bits and sets the order to 1.
// ----------------------------------------------------------------------------
module euler_to_quaternion_converter_top import eul2q_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  angles_t     angles,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LAT = CORDIC_STAGES + 4;

  logic order;
  logic [LAT-1:0] vpipe;
  trig_t sx, cx, sy, cy, sz, cz;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COMPONENT_ORDER) ? {31'b0, order} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_COMPONENT_ORDER) begin
      order <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start & ~busy};
    end
  end

  assign done = vpipe[LAT-1];

  eul2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_lane_x (
    .clk(clk), .angle(angles.roll_angle), .sin_out(sx), .cos_out(cx));
  eul2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_lane_y (
    .clk(clk), .angle(angles.pitch_angle), .sin_out(sy), .cos_out(cy));
  eul2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_lane_z (
    .clk(clk), .angle(angles.yaw_angle), .sin_out(sz), .cos_out(cz));

  eul2q_merge u_merge (
    .clk(clk), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .order(order), .result(result));

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("result missing after start");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.component_a <= 16'sd16384 && result.component_a >= -16'sd16384 &&
              result.component_d <= 16'sd16384 && result.component_d >= -16'sd16384))
    else $error("component out of range");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == REG_COMPONENT_ORDER) |=> order == $past(pwdata[0]))
    else $error("order register not written");

endmodule
